### rtl/core/mtac_pkg.sv
// Shared types, character codes and helper functions of the markup to ANSI converter.
// Depends on nothing; every other file of the block uses it.
package mtac_pkg;

    // Depth of the command queue between the front and back parts.
    localparam int CMD_FIFO_DEPTH = 2;

    // Width of the per-command byte count (at most ten bytes per command).
    localparam int LEN_W = 4;

    // Character codes.
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D1     = 8'h31;
    localparam logic [7:0] CH_D3     = 8'h33;
    localparam logic [7:0] CH_D4     = 8'h34;
    localparam logic [7:0] CH_D5     = 8'h35;

    // Input item and result item.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       run_last;
    } t_out_item;

    // Kind of output sequence that one command expands into.
    typedef enum logic [2:0] {
        CMD_MARK,   // bare end marker, no byte
        CMD_RAW,    // one to three literal bytes
        CMD_SGR,    // ESC [ 1 ; d m
        CMD_COLOR,  // ESC [ 1 ; p d m
        CMD_BOTH    // ESC [ 1 ; 4 b ; 3 f m
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind        kind;
        logic [LEN_W-1:0] len;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
    } t_cmd;

    // ASCII color digit of a color letter, or zero when the byte names no color.
    function automatic logic [7:0] color_digit(input logic [7:0] c);
        logic [7:0] lc;
        lc = c | 8'h20;
        case (lc)
            8'h62:   color_digit = 8'h34; // b
            8'h63:   color_digit = 8'h36; // c
            8'h67:   color_digit = 8'h32; // g
            8'h6C:   color_digit = 8'h30; // l
            8'h6D:   color_digit = 8'h35; // m
            8'h72:   color_digit = 8'h31; // r
            8'h77:   color_digit = 8'h37; // w
            8'h79:   color_digit = 8'h33; // y
            default: color_digit = CH_NUL;
        endcase
    endfunction

    // Byte at position idx of the sequence that a command expands into.
    function automatic logic [7:0] cmd_byte(input t_cmd cmd, input logic [LEN_W-1:0] idx);
        logic [7:0] r;
        r = CH_NUL;
        case (cmd.kind)
            CMD_RAW: begin
                case (idx)
                    4'd0:    r = cmd.b0;
                    4'd1:    r = cmd.b1;
                    default: r = cmd.b2;
                endcase
            end
            CMD_SGR, CMD_COLOR, CMD_BOTH: begin
                case (idx)
                    4'd0:    r = CH_ESC;
                    4'd1:    r = CH_LBRACK;
                    4'd2:    r = CH_D1;
                    4'd3:    r = CH_SEMI;
                    4'd4:    r = (cmd.kind == CMD_BOTH) ? CH_D4 : cmd.b0;
                    4'd5: begin
                        case (cmd.kind)
                            CMD_SGR:   r = CH_M;
                            CMD_COLOR: r = cmd.b1;
                            default:   r = cmd.b0;
                        endcase
                    end
                    4'd6:    r = (cmd.kind == CMD_BOTH) ? CH_SEMI : CH_M;
                    4'd7:    r = CH_D3;
                    4'd8:    r = cmd.b1;
                    default: r = CH_M;
                endcase
            end
            default: r = CH_NUL;
        endcase
        return r;
    endfunction

endpackage

### rtl/core/mtac_front.sv
// Front part of the converter: accepts input bytes, tracks the markup state and
// classifies each byte into at most one output command. Depends on mtac_pkg.
module mtac_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mtac_pkg::t_in_item i_item,
    input  logic               i_full,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_data,
    output logic               o_cmd_push,
    output mtac_pkg::t_cmd     o_cmd
);

    typedef enum logic [2:0] {
        MODE_PLAIN,
        MODE_AMP,
        MODE_FGBG,
        MODE_BOTH1,
        MODE_BOTH2
    } t_mode;

    t_mode          r_mode, n_mode;
    logic           r_bsel, n_bsel;
    logic [7:0]     r_held, n_held;
    logic           r_cr, n_cr;
    logic           r_color_enable;
    mtac_pkg::t_cmd n_cmd;

    logic       accept;
    logic [7:0] c;
    logic [7:0] dig_c;
    logic [7:0] dig_held;

    assign accept   = i_push && !i_full;
    assign c        = i_item.text_byte;
    assign dig_c    = mtac_pkg::color_digit(c);
    assign dig_held = mtac_pkg::color_digit(r_held);

    // Classify the byte against the current mode and build its command.
    always_comb begin
        n_mode = MODE_PLAIN;
        n_bsel = r_bsel;
        n_held = r_held;
        n_cr   = 1'b0;
        n_cmd  = '{kind: mtac_pkg::CMD_RAW, len: '0,
                   b0: mtac_pkg::CH_NUL, b1: mtac_pkg::CH_NUL, b2: mtac_pkg::CH_NUL};

        case (r_mode)
            MODE_AMP: begin
                case (c)
                    mtac_pkg::CH_AMP: begin
                        n_cmd.b0  = mtac_pkg::CH_AMP;
                        n_cmd.len = 4'd1;
                    end
                    mtac_pkg::CH_STAR, mtac_pkg::CH_CARET, mtac_pkg::CH_TILDE,
                    mtac_pkg::CH_UNDER, mtac_pkg::CH_AT: begin
                        if (r_color_enable) begin
                            n_cmd.kind = mtac_pkg::CMD_SGR;
                            n_cmd.len  = 4'd6;
                            case (c)
                                mtac_pkg::CH_STAR:  n_cmd.b0 = mtac_pkg::CH_D0;
                                mtac_pkg::CH_CARET: n_cmd.b0 = mtac_pkg::CH_D1;
                                mtac_pkg::CH_TILDE: n_cmd.b0 = mtac_pkg::CH_D3;
                                mtac_pkg::CH_UNDER: n_cmd.b0 = mtac_pkg::CH_D4;
                                default:            n_cmd.b0 = mtac_pkg::CH_D5;
                            endcase
                        end
                    end
                    mtac_pkg::CH_PLUS, mtac_pkg::CH_MINUS: begin
                        n_bsel = (c == mtac_pkg::CH_MINUS);
                        n_mode = MODE_FGBG;
                    end
                    mtac_pkg::CH_EQ: begin
                        n_mode = MODE_BOTH1;
                    end
                    default: begin
                        // Unknown pair: the ampersand, then the byte as plain text.
                        n_cmd.b0 = mtac_pkg::CH_AMP;
                        if (c == mtac_pkg::CH_LF) begin
                            n_cmd.b1  = mtac_pkg::CH_CR;
                            n_cmd.b2  = mtac_pkg::CH_LF;
                            n_cmd.len = 4'd3;
                        end else begin
                            n_cmd.b1  = c;
                            n_cmd.len = 4'd2;
                        end
                        n_cr = (c == mtac_pkg::CH_CR);
                    end
                endcase
            end
            MODE_FGBG: begin
                if (r_color_enable && dig_c != mtac_pkg::CH_NUL) begin
                    n_cmd.kind = mtac_pkg::CMD_COLOR;
                    n_cmd.len  = 4'd7;
                    n_cmd.b0   = r_bsel ? mtac_pkg::CH_D4 : mtac_pkg::CH_D3;
                    n_cmd.b1   = dig_c;
                end
            end
            MODE_BOTH1: begin
                n_held = c;
                n_mode = MODE_BOTH2;
            end
            MODE_BOTH2: begin
                if (r_color_enable && dig_held != mtac_pkg::CH_NUL
                        && dig_c != mtac_pkg::CH_NUL) begin
                    n_cmd.kind = mtac_pkg::CMD_BOTH;
                    n_cmd.len  = 4'd10;
                    n_cmd.b0   = dig_held;
                    n_cmd.b1   = dig_c;
                end
            end
            default: begin
                if (c == mtac_pkg::CH_AMP) begin
                    n_mode = MODE_AMP;
                end else begin
                    if (c == mtac_pkg::CH_LF && !r_cr) begin
                        n_cmd.b0  = mtac_pkg::CH_CR;
                        n_cmd.b1  = mtac_pkg::CH_LF;
                        n_cmd.len = 4'd2;
                    end else begin
                        n_cmd.b0  = c;
                        n_cmd.len = 4'd1;
                    end
                    n_cr = (c == mtac_pkg::CH_CR);
                end
            end
        endcase

        // At the end of a message an open code is copied out raw and all markup state clears.
        // An open code always comes from a byte that produced nothing itself.
        if (i_item.message_end) begin
            case (n_mode)
                MODE_AMP: begin
                    n_cmd.b0  = mtac_pkg::CH_AMP;
                    n_cmd.len = 4'd1;
                end
                MODE_FGBG: begin
                    n_cmd.b0  = mtac_pkg::CH_AMP;
                    n_cmd.b1  = n_bsel ? mtac_pkg::CH_MINUS : mtac_pkg::CH_PLUS;
                    n_cmd.len = 4'd2;
                end
                MODE_BOTH1: begin
                    n_cmd.b0  = mtac_pkg::CH_AMP;
                    n_cmd.b1  = mtac_pkg::CH_EQ;
                    n_cmd.len = 4'd2;
                end
                MODE_BOTH2: begin
                    n_cmd.b0  = mtac_pkg::CH_AMP;
                    n_cmd.b1  = mtac_pkg::CH_EQ;
                    n_cmd.b2  = n_held;
                    n_cmd.len = 4'd3;
                end
                default: begin
                end
            endcase
            if (n_cmd.len == '0) begin
                n_cmd.kind = mtac_pkg::CMD_MARK;
                n_cmd.len  = 4'd1;
            end
            n_mode = MODE_PLAIN;
            n_bsel = 1'b0;
            n_held = mtac_pkg::CH_NUL;
            n_cr   = 1'b0;
        end
    end

    assign o_cmd_push = accept && (n_cmd.len != '0);
    assign o_cmd      = n_cmd;

    // Markup state and the color enable register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_PLAIN;
            r_bsel         <= 1'b0;
            r_held         <= mtac_pkg::CH_NUL;
            r_cr           <= 1'b0;
            r_color_enable <= 1'b1;
        end else begin
            if (accept) begin
                r_mode <= n_mode;
                r_bsel <= n_bsel;
                r_held <= n_held;
                r_cr   <= n_cr;
            end
            if (i_cfg_valid) begin
                r_color_enable <= i_cfg_data;
            end
        end
    end

endmodule

### rtl/core/mtac_cmd_fifo.sv
// Short command queue between the front and back parts of the converter.
// Depends on mtac_pkg for the command type.
module mtac_cmd_fifo #(
    parameter int DEPTH = mtac_pkg::CMD_FIFO_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mtac_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mtac_pkg::t_cmd o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mtac_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp, r_rp;
    logic [CW-1:0]  r_count;
    logic           do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/mtac_back.sv
// Back part of the converter: expands each queued command into result bytes, one
// per cycle while the reader pops, into an output register. Depends on mtac_pkg.
module mtac_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  mtac_pkg::t_cmd      i_cmd,
    output logic                o_cmd_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output mtac_pkg::t_out_item o_data
);

    logic [mtac_pkg::LEN_W-1:0] r_idx;
    logic                       r_out_valid;
    mtac_pkg::t_out_item        r_out;
    logic                       load;
    logic                       last;

    // A new byte enters the output register when it is free or being transferred.
    assign load      = i_cmd_valid && (!r_out_valid || i_pop);
    assign last      = (r_idx + 1'b1) == i_cmd.len;
    assign o_cmd_pop = load && last;
    assign o_empty   = !r_out_valid;
    assign o_data    = r_out;

    // Byte index within the current command and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= last ? '0 : r_idx + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.out_char   <= mtac_pkg::cmd_byte(i_cmd, r_idx);
            r_out.char_valid <= (i_cmd.kind != mtac_pkg::CMD_MARK);
            r_out.run_last   <= last;
        end
    end

endmodule

### rtl/core/markup_to_ansi_text_converter_top.sv
// Markup to ANSI converter. An input byte is accepted every cycle while the command
// queue has room; its first result byte passes through the command queue and then the
// output register before it is offered. One result byte leaves per cycle while the
// reader pops; a byte with up to ten results holds the back part until all have left.
// Reset is synchronous, active low: it clears the markup state, the queue and the
// output register, and sets color_enable to one. Depends on mtac_pkg and submodules.
module markup_to_ansi_text_converter_top #(
    parameter int CMD_DEPTH = mtac_pkg::CMD_FIFO_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  mtac_pkg::t_in_item  i_data,
    output logic                empty,
    input  logic                pop,
    output mtac_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    logic           cmd_push;
    mtac_pkg::t_cmd cmd_in;
    logic           cmd_full;
    logic           cmd_valid;
    logic           cmd_pop;
    mtac_pkg::t_cmd cmd_head;

    // The configuration register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign full        = cmd_full;

    mtac_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_data),
        .i_full      (cmd_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in)
    );

    mtac_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_head)
    );

    mtac_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_data      (o_data)
    );

`ifndef SYNTHESIS
    // Only the final result of an item may lack a byte.
    a_mark_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.char_valid) |-> o_data.run_last)
        else $error("end marker without run_last");

    // A bare end marker carries a zero byte.
    a_mark_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_data.char_valid) |-> (o_data.out_char == 8'h00))
        else $error("end marker with nonzero byte");

    // Nothing is offered right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result offered after reset");
`endif

endmodule
